@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion helper macros used by the queue design file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, held off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// implication checked on the following clock edge
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/fqcr_pkg.sv @@
// ---------------------------------------------------------------------------
// fqcr_pkg
// shared types for the cursor queue: op codes, word layouts, cell commands
// ---------------------------------------------------------------------------
package fqcr_pkg;

  // field widths fixed by the channel layout
  localparam int OP_W    = 3;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  // queue operations
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_TO_HEAD = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_REMOVE  = 3'd4
  } op_t;

  // input word
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] value_in;
  } in_word_t;

  // result word
  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] value_out;
    logic [COUNT_W-1:0]       count;
    logic                     cursor_valid;
    logic signed [WORD_W-1:0] cursor_value;
  } out_word_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic push;     // append at the first empty cell
    logic pop;      // shift the whole row toward the head
    logic to_head;  // cursor mark covers the whole row
    logic advance;  // cursor mark steps one cell toward the tail
    logic remove;   // cells at or behind the cursor shift toward the head
    logic kill;     // cursor becomes invalid with this pop or remove
  } cell_cmd_t;

endpackage

@@ design/fifo_queue_with_cursor_removal.sv @@
// ---------------------------------------------------------------------------
// fifo_queue_with_cursor_removal
// ordered queue of signed words with a cursor, built as a row of slot cells
// ---------------------------------------------------------------------------
//  channel  | ports                         | moves
//  ---------+-------------------------------+------------------------------
//  input    | in_valid, in_ready, in_word   | op and word to append
//  result   | out_valid, out_ready, out_word| status, removed word, cursor
//
//  one word per cycle while in_ready is high: every cell updates in the
//  accepting cycle, and the result is loaded into an output register
//  the slot row shifts toward the head in parallel on pop and removal
//  in_ready stays high while the output register is empty or being taken
//  reset clears occupancy, cursor marks, count and the valid bit of the output register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_queue_with_cursor_removal #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fqcr_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output fqcr_pkg::out_word_t out_word
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = fqcr_pkg::WORD_W;

  // sign-extend a stored word to the result width
  function automatic logic [WW-1:0] widen(input logic [DATA_WIDTH-1:0] d);
    logic [DATA_WIDTH+WW-1:0] ext;
    ext = {{WW{d[DATA_WIDTH-1]}}, d};
    return ext[WW-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] data_vec [DEPTH];
  logic [DEPTH-1:0]      occ_vec, mark_vec, flag_vec, succ_sel;
  logic [DATA_WIDTH-1:0] push_data, cur_val, succ_val;
  logic                  live, succ_exists, accept;
  logic [CW-1:0]         count_r, count_nxt;
  fqcr_pkg::cell_cmd_t   cmd, cell_cmd;
  fqcr_pkg::out_word_t   res, out_word_r;
  logic                  out_valid_r;

  // stored form of the incoming word
  logic [DATA_WIDTH+WW-1:0] push_ext;
  assign push_ext  = {{DATA_WIDTH{1'b0}}, in_word.value_in};
  assign push_data = push_ext[DATA_WIDTH-1:0];

  // handshake
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // cursor decode from the thermometer marks
  assign live     = mark_vec[DEPTH-1];
  assign flag_vec = mark_vec & ~{mark_vec[DEPTH-2:0], 1'b0};
  assign succ_sel = {flag_vec[DEPTH-2:0], 1'b0};

  // one-hot selects of the cursor word and its successor
  always_comb begin
    cur_val  = '0;
    succ_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      cur_val  = cur_val  | (flag_vec[i] ? data_vec[i] : '0);
      succ_val = succ_val | (succ_sel[i] ? data_vec[i] : '0);
    end
  end
  assign succ_exists = |(succ_sel & occ_vec);

  // operation decode, cell command and result
  always_comb begin
    cmd                = '0;
    count_nxt          = count_r;
    res                = '0;
    res.cursor_valid   = live;
    res.cursor_value   = live ? widen(cur_val) : '0;
    case (fqcr_pkg::op_t'(in_word.op))
      fqcr_pkg::OP_PUSH: begin
        if (!occ_vec[DEPTH-1]) begin
          cmd.push  = 1'b1;
          count_nxt = count_r + CW'(1);
          res.ok    = 1'b1;
        end
      end
      fqcr_pkg::OP_POP: begin
        if (occ_vec[0]) begin
          cmd.pop       = 1'b1;
          cmd.kill      = live && mark_vec[0] && !occ_vec[1];
          count_nxt     = count_r - CW'(1);
          res.ok        = 1'b1;
          res.value_out = widen(data_vec[0]);
          if (live && mark_vec[0]) begin
            res.cursor_valid = occ_vec[1];
            res.cursor_value = occ_vec[1] ? widen(data_vec[1]) : '0;
          end
        end
      end
      fqcr_pkg::OP_TO_HEAD: begin
        if (occ_vec[0]) begin
          cmd.to_head      = 1'b1;
          res.ok           = 1'b1;
          res.cursor_valid = 1'b1;
          res.cursor_value = widen(data_vec[0]);
        end
      end
      fqcr_pkg::OP_ADVANCE: begin
        if (live) begin
          cmd.advance = succ_exists;
          res.ok      = 1'b1;
          if (succ_exists) begin
            res.cursor_value = widen(succ_val);
          end
        end
      end
      fqcr_pkg::OP_REMOVE: begin
        if (live) begin
          cmd.remove       = 1'b1;
          cmd.kill         = !succ_exists;
          count_nxt        = count_r - CW'(1);
          res.ok           = 1'b1;
          res.value_out    = widen(cur_val);
          res.cursor_valid = succ_exists;
          res.cursor_value = succ_exists ? widen(succ_val) : '0;
        end
      end
      default: begin
      end
    endcase
    res.count = fqcr_pkg::COUNT_W'(count_nxt);
  end

  assign cell_cmd = accept ? cmd : '0;

  // slot row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                  occ_h, mark_h, occ_t, mark_t;
    logic [DATA_WIDTH-1:0] data_t;
    if (g == 0) begin : g_head
      assign occ_h  = 1'b1;
      assign mark_h = 1'b0;
    end else begin : g_mid_h
      assign occ_h  = occ_vec[g-1];
      assign mark_h = mark_vec[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign data_t = data_vec[g];
      assign occ_t  = 1'b0;
      assign mark_t = mark_vec[g];
    end else begin : g_mid_t
      assign data_t = data_vec[g+1];
      assign occ_t  = occ_vec[g+1];
      assign mark_t = mark_vec[g+1];
    end
    fqcr_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .cmd           (cell_cmd),
      .push_data     (push_data),
      .occ_head_side (occ_h),
      .mark_head_side(mark_h),
      .data_tail_side(data_t),
      .occ_tail_side (occ_t),
      .mark_tail_side(mark_t),
      .data          (data_vec[g]),
      .occ           (occ_vec[g]),
      .mark          (mark_vec[g])
    );
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  `ASSERT_CLK(a_occ_count, clk, rst_n, $countones(occ_vec) == count_r, "occupancy vs count")
  `ASSERT_CLK(a_cursor_onehot, clk, rst_n, $onehot0(flag_vec), "cursor mark broken")
  `ASSERT_CLK(a_cursor_held, clk, rst_n, !live || occ_vec[0], "cursor on empty queue")
  `ASSERT_NEXT(a_fail_hold, clk, rst_n, accept && !res.ok, $stable(count_r), "count moved")

endmodule

@@ design/fqcr_cell.sv @@
// ---------------------------------------------------------------------------
// fqcr_cell
// one queue slot: stored word, occupancy bit and cursor mark, talking to the
// neighbor on each side
// ---------------------------------------------------------------------------
module fqcr_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fqcr_pkg::cell_cmd_t   cmd,
  input  logic [DATA_WIDTH-1:0] push_data,
  // neighbor toward the head
  input  logic                  occ_head_side,
  input  logic                  mark_head_side,
  // neighbor toward the tail
  input  logic [DATA_WIDTH-1:0] data_tail_side,
  input  logic                  occ_tail_side,
  input  logic                  mark_tail_side,
  // this slot
  output logic [DATA_WIDTH-1:0] data,
  output logic                  occ,
  output logic                  mark
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  occ_r, occ_nxt;
  logic                  mark_r, mark_nxt;

  // next slot contents
  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    mark_nxt = mark_r;
    if (cmd.push) begin
      occ_nxt = occ_r | occ_head_side;
      if (!occ_r && occ_head_side) begin
        data_nxt = push_data;
      end
    end else if (cmd.pop) begin
      data_nxt = data_tail_side;
      occ_nxt  = occ_tail_side;
      mark_nxt = cmd.kill ? 1'b0 : mark_tail_side;
    end else if (cmd.to_head) begin
      mark_nxt = 1'b1;
    end else if (cmd.advance) begin
      mark_nxt = mark_head_side;
    end else if (cmd.remove) begin
      if (mark_r) begin
        data_nxt = data_tail_side;
      end
      occ_nxt = occ_tail_side;
      if (cmd.kill) begin
        mark_nxt = 1'b0;
      end
    end
  end

  // control bits reset, the word does not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= 1'b0;
      mark_r <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      mark_r <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign occ  = occ_r;
  assign mark = mark_r;

endmodule
